// ===== rtl/sbsi_pkg.sv =====
// shared types and constants for the segment/box slab intersect core
// no dependencies
package sbsi_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } cfg_idx_t;

endpackage

// ===== rtl/sbsi_div.sv =====
// pipelined restoring divider: quotient of n/d with frac bits, saturated at 2.0
// one quotient bit per stage; depends on sbsi_pkg
module sbsi_div #(
    parameter int NW = sbsi_pkg::COORD_BITS + 1,
    parameter int FB = sbsi_pkg::FRAC_BITS
)(
    input  logic                 clk,
    input  logic                 en,
    input  logic [NW-1:0]        n,
    input  logic [NW-1:0]        d,
    input  logic                 neg,
    output logic signed [FB+2:0] q
);
    localparam int ST = FB + 1;

    logic [NW:0]   r_reg [ST+1];
    logic [NW-1:0] d_reg [ST+1];
    logic [FB+1:0] m_reg [ST+1];
    logic          s_reg [ST+1];
    logic          n_reg [ST+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= {1'b0, n};
            d_reg[0] <= d;
            m_reg[0] <= '0;
            s_reg[0] <= ({1'b0, n} >= {d, 1'b0});
            n_reg[0] <= neg;
        end
    end

    for (genvar k = 0; k < ST; k++)
    begin : g_stage
        logic [NW+1:0] rs;
        logic [NW:0]   r_next;
        logic          b;
        always_comb
        begin
            rs = (k == 0) ? {1'b0, r_reg[k]} : {r_reg[k], 1'b0};
            b  = rs >= {2'b0, d_reg[k]};
            r_next = b ? (NW+1)'(rs - {2'b0, d_reg[k]}) : rs[NW:0];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1] <= r_next;
                d_reg[k+1] <= d_reg[k];
                m_reg[k+1] <= {m_reg[k][FB:0], b};
                s_reg[k+1] <= s_reg[k];
                n_reg[k+1] <= n_reg[k];
            end
        end
    end

    logic [FB+2:0] mm;
    always_comb
    begin
        mm = s_reg[ST] ? (FB+3)'(2) << FB : {1'b0, m_reg[ST]};
        q  = n_reg[ST] ? -$signed(mm) : $signed(mm);
    end
endmodule

// ===== rtl/sbsi_sqrt.sv =====
// pipelined bit-serial integer square root, one result bit per stage
// depends on sbsi_pkg
module sbsi_sqrt #(
    parameter int RW = sbsi_pkg::COORD_BITS,
    parameter int TW = 1
)(
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW+1:0] sq,
    input  logic [TW-1:0]   tag_in,
    output logic [RW-1:0]   root,
    output logic [TW-1:0]   tag_out
);
    logic [2*RW+1:0] s_reg [RW+1];
    logic [RW-1:0]   r_reg [RW+1];
    logic [TW-1:0]   t_reg [RW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= sq;
            r_reg[0] <= '0;
            t_reg[0] <= tag_in;
        end
    end

    for (genvar k = 0; k < RW; k++)
    begin : g_bit
        localparam int B = RW - 1 - k;
        logic [RW-1:0]   c;
        logic [2*RW-1:0] cc;
        always_comb
        begin
            c  = r_reg[k] | (RW'(1) << B);
            cc = c * c;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[k+1] <= s_reg[k];
                r_reg[k+1] <= ({2'b0, cc} <= s_reg[k]) ? c : r_reg[k];
                t_reg[k+1] <= t_reg[k];
            end
        end
    end

    assign root    = r_reg[RW];
    assign tag_out = t_reg[RW];
endmodule

// ===== rtl/segment_box_slab_intersect_core.sv =====
// channel | dir | payload (low bit first)
// s_axis  | in  | start_x, start_y, start_z, end_x, end_y, end_z
// m_axis  | out | hit, distance, entry_x, entry_y, entry_z (+7 zero bits)
// cfg     | in  | wr_en, wr_idx, wr_data
// one item per cycle while the output is not stalled; the pipeline depth is set mostly by
// the divider (FRAC_BITS+2) and square root (COORD_BITS+1) pipelines
// reset clears valid bits and loads the inverted box (always a miss)
// the whole pipe advances only when the output register is free or taken
// depends on sbsi_pkg, sbsi_div, sbsi_sqrt
module segment_box_slab_intersect_core #(
    parameter int COORD_BITS = sbsi_pkg::COORD_BITS,
    parameter int FRAC_BITS  = sbsi_pkg::FRAC_BITS
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [6*COORD_BITS-1:0]       s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hit, distance, entry_x, entry_y, entry_z, zero fill
    output logic [((4*COORD_BITS+1+7)/8)*8-1:0] m_axis_tdata,
    input  logic                          wr_en,
    input  logic [sbsi_pkg::CFG_IDX_BITS-1:0] wr_idx,
    input  logic [COORD_BITS-1:0]         wr_data
);
    localparam int CW = COORD_BITS;
    localparam int FB = FRAC_BITS;
    localparam int DW = CW + 1;
    localparam int QW = FB + 3;
    localparam int OW = ((4*CW+1+7)/8)*8;
    localparam int DL = FB + 2;
    localparam int SL = CW + 1;

    logic signed [CW-1:0] bmin_reg [3];
    logic signed [CW-1:0] bmax_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bmin_reg[i] <= {1'b0, {(CW-1){1'b1}}};
                bmax_reg[i] <= {1'b1, {(CW-1){1'b0}}};
            end
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                sbsi_pkg::REG_MIN_X: bmin_reg[0] <= wr_data;
                sbsi_pkg::REG_MIN_Y: bmin_reg[1] <= wr_data;
                sbsi_pkg::REG_MIN_Z: bmin_reg[2] <= wr_data;
                sbsi_pkg::REG_MAX_X: bmax_reg[0] <= wr_data;
                sbsi_pkg::REG_MAX_Y: bmax_reg[1] <= wr_data;
                sbsi_pkg::REG_MAX_Z: bmax_reg[2] <= wr_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic out_v_reg;
    assign en = !out_v_reg || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: deltas, numerators, parallel tests
    logic                 v1_reg;
    logic signed [CW-1:0] s1_reg [3];
    logic signed [DW-1:0] d1_reg [3];
    logic signed [DW:0]   na1_reg [3];
    logic signed [DW:0]   nb1_reg [3];
    logic                 ok1_reg;
    logic [2:0]           par1_reg;

    logic                 ok_c;
    logic signed [CW-1:0] si [3];
    logic signed [CW-1:0] ei [3];
    always_comb
    begin
        ok_c = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            si[i] = s_axis_tdata[i*CW +: CW];
            ei[i] = s_axis_tdata[(i+3)*CW +: CW];
            if (bmin_reg[i] > bmax_reg[i])
                ok_c = 1'b0;
            if (si[i] == ei[i] && (si[i] < bmin_reg[i] || si[i] > bmax_reg[i]))
                ok_c = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok1_reg <= ok_c;
            for (int i = 0; i < 3; i++)
            begin
                s1_reg[i]  <= si[i];
                d1_reg[i]  <= DW'(ei[i]) - DW'(si[i]);
                na1_reg[i] <= (DW+1)'(bmin_reg[i]) - (DW+1)'(si[i]);
                nb1_reg[i] <= (DW+1)'(bmax_reg[i]) - (DW+1)'(si[i]);
                par1_reg[i] <= (si[i] == ei[i]);
            end
        end
    end

    // stage 2: magnitudes for the dividers
    logic                 v2_reg;
    logic [DW:0]          an2_reg [3];
    logic [DW:0]          bn2_reg [3];
    logic [DW:0]          dm2_reg [3];
    logic [2:0]           an2neg_reg;
    logic [2:0]           bn2neg_reg;
    logic signed [CW-1:0] s2_reg [3];
    logic signed [DW-1:0] d2_reg [3];
    logic                 ok2_reg;
    logic [2:0]           par2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok2_reg  <= ok1_reg;
            par2_reg <= par1_reg;
            for (int i = 0; i < 3; i++)
            begin
                an2_reg[i] <= na1_reg[i][DW] ? -na1_reg[i] : na1_reg[i];
                bn2_reg[i] <= nb1_reg[i][DW] ? -nb1_reg[i] : nb1_reg[i];
                dm2_reg[i] <= d1_reg[i][DW-1] ? (DW+1)'(-d1_reg[i])
                                              : (DW+1)'(d1_reg[i]);
                an2neg_reg[i] <= na1_reg[i][DW] ^ d1_reg[i][DW-1];
                bn2neg_reg[i] <= nb1_reg[i][DW] ^ d1_reg[i][DW-1];
                s2_reg[i] <= s1_reg[i];
                d2_reg[i] <= d1_reg[i];
            end
        end
    end

    // divider bank; side data and valid ride in matching delay lines
    logic signed [QW-1:0] qa [3];
    logic signed [QW-1:0] qb [3];
    localparam int TW = 3*CW + 3*DW + 4;
    logic [TW-1:0] tag_out;
    logic [TW-1:0] side_reg [DL];
    logic          vd_reg [DL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DL; k++)
                vd_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vd_reg[0] <= v2_reg;
            for (int k = 1; k < DL; k++)
                vd_reg[k] <= vd_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= {ok2_reg, par2_reg,
                            s2_reg[2], s2_reg[1], s2_reg[0],
                            d2_reg[2], d2_reg[1], d2_reg[0]};
            for (int k = 1; k < DL; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end
    assign tag_out = side_reg[DL-1];

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        sbsi_div #(.NW(DW+1), .FB(FB)) u_da (
            .clk(clk), .en(en), .n(an2_reg[i]), .d(dm2_reg[i]),
            .neg(an2neg_reg[i]), .q(qa[i]));
        sbsi_div #(.NW(DW+1), .FB(FB)) u_db (
            .clk(clk), .en(en), .n(bn2_reg[i]), .d(dm2_reg[i]),
            .neg(bn2neg_reg[i]), .q(qb[i]));
    end

    logic                 v3;
    logic                 ok3;
    logic [2:0]           par3;
    logic signed [CW-1:0] s3 [3];
    logic signed [DW-1:0] d3 [3];
    always_comb
    begin
        v3   = vd_reg[DL-1];
        ok3  = tag_out[TW-1];
        par3 = tag_out[TW-2 -: 3];
        for (int i = 0; i < 3; i++)
        begin
            s3[i] = tag_out[3*DW + i*CW +: CW];
            d3[i] = tag_out[i*DW +: DW];
        end
    end

    // interval narrowing, one axis per stage
    logic                 vi_reg  [4];
    logic                 oki_reg [4];
    logic signed [QW-1:0] lo_reg  [4];
    logic signed [QW-1:0] hi_reg  [4];
    logic signed [QW-1:0] qa_reg  [4][3];
    logic signed [QW-1:0] qb_reg  [4][3];
    logic [2:0]           pari_reg [4];
    logic signed [CW-1:0] si_reg  [4][3];
    logic signed [DW-1:0] di_reg  [4][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vi_reg[0] <= 1'b0;
        else if (en)
            vi_reg[0] <= v3;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oki_reg[0]  <= ok3;
            lo_reg[0]   <= '0;
            hi_reg[0]   <= QW'(1) << FB;
            pari_reg[0] <= par3;
            for (int i = 0; i < 3; i++)
            begin
                qa_reg[0][i] <= qa[i];
                qb_reg[0][i] <= qb[i];
                si_reg[0][i] <= s3[i];
                di_reg[0][i] <= d3[i];
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        logic signed [QW-1:0] a;
        logic signed [QW-1:0] b;
        logic                 ok_n;
        logic signed [QW-1:0] lo_n;
        logic signed [QW-1:0] hi_n;
        always_comb
        begin
            a = (qb_reg[k][k] < qa_reg[k][k]) ? qb_reg[k][k] : qa_reg[k][k];
            b = (qb_reg[k][k] < qa_reg[k][k]) ? qa_reg[k][k] : qb_reg[k][k];
            ok_n = oki_reg[k];
            lo_n = lo_reg[k];
            hi_n = hi_reg[k];
            if (oki_reg[k] && !pari_reg[k][k])
            begin
                if (b < lo_reg[k] || a > hi_reg[k])
                    ok_n = 1'b0;
                else
                begin
                    if (a > lo_reg[k])
                        lo_n = a;
                    if (b < hi_reg[k])
                        hi_n = b;
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vi_reg[k+1] <= 1'b0;
            else if (en)
                vi_reg[k+1] <= vi_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                oki_reg[k+1]  <= ok_n;
                lo_reg[k+1]   <= lo_n;
                hi_reg[k+1]   <= hi_n;
                qa_reg[k+1]   <= qa_reg[k];
                qb_reg[k+1]   <= qb_reg[k];
                pari_reg[k+1] <= pari_reg[k];
                si_reg[k+1]   <= si_reg[k];
                di_reg[k+1]   <= di_reg[k];
            end
        end
    end

    // offset scaling: |d| * low >> FB, then sign
    logic                 vm_reg;
    logic                 okm_reg;
    logic [DW+FB:0]       pm_reg [3];
    logic [2:0]           negm_reg;
    logic signed [CW-1:0] sm_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else if (en)
            vm_reg <= vi_reg[3];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            okm_reg <= oki_reg[3];
            for (int i = 0; i < 3; i++)
            begin
                pm_reg[i] <= (DW+FB+1)'(di_reg[3][i][DW-1] ? -di_reg[3][i]
                                                           : di_reg[3][i])
                             * (DW+FB+1)'(lo_reg[3][FB:0]);
                negm_reg[i] <= di_reg[3][i][DW-1];
                sm_reg[i]   <= si_reg[3][i];
            end
        end
    end

    logic                 vo_reg;
    logic                 oko_reg;
    logic [DW-1:0]        mo_reg [3];
    logic signed [CW-1:0] eo_reg [3];
    logic [2*CW+1:0]      sq_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= vm_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oko_reg <= okm_reg;
            for (int i = 0; i < 3; i++)
            begin
                mo_reg[i] <= DW'(pm_reg[i] >> FB);
                eo_reg[i] <= negm_reg[i] ? sm_reg[i] - CW'(pm_reg[i] >> FB)
                                         : sm_reg[i] + CW'(pm_reg[i] >> FB);
            end
        end
    end

    // squares, registered, then summed into the root pipe
    logic                 vq_reg;
    logic                 okq_reg;
    logic [2*DW-1:0]      q2_reg [3];
    logic signed [CW-1:0] eq_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq_reg <= 1'b0;
        else if (en)
            vq_reg <= vo_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            okq_reg <= oko_reg;
            for (int i = 0; i < 3; i++)
            begin
                q2_reg[i] <= mo_reg[i] * mo_reg[i];
                eq_reg[i] <= eo_reg[i];
            end
        end
    end

    assign sq_c = (2*CW+2)'(q2_reg[0]) + (2*CW+2)'(q2_reg[1]) + (2*CW+2)'(q2_reg[2]);

    localparam int RT = 3*CW + 1;
    logic [RT-1:0] rtag_out;
    logic [CW-1:0] root;
    logic          vs_reg [SL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SL; k++)
                vs_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vs_reg[0] <= vq_reg;
            for (int k = 1; k < SL; k++)
                vs_reg[k] <= vs_reg[k-1];
        end
    end

    sbsi_sqrt #(.RW(CW), .TW(RT)) u_sqrt (
        .clk(clk), .en(en), .sq(sq_c),
        .tag_in({okq_reg, eq_reg[2], eq_reg[1], eq_reg[0]}),
        .root(root), .tag_out(rtag_out));

    logic [OW-1:0] out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= vs_reg[SL-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rtag_out[RT-1])
                out_reg <= OW'({rtag_out[3*CW-1:0], root, 1'b1});
            else
                out_reg <= '0;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_reg;
endmodule

// ===== test/tb.sv =====
// testbench for segment_box_slab_intersect_core: segments are clipped against
// programmed boxes, every result is checked against a slab-method predictor
// depends on sbsi_pkg and the core rtl
`timescale 1ns / 1ps

module tb;
    localparam int CB = sbsi_pkg::COORD_BITS;
    localparam int FB = sbsi_pkg::FRAC_BITS;
    localparam int OUT_W = ((4*CB+1+7)/8)*8;
    localparam int LATENCY = 2*CB + FB + 8;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CB-1:0] ez, ey, ex, sz, sy, sx;
    } seg_t;

    typedef struct {
        logic          hit;
        logic [CB-1:0] distance;
        logic [CB-1:0] px, py, pz;
    } clip_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [6*CB-1:0] s_axis_tdata = '0;  // start_x, start_y, start_z, end_x, end_y, end_z
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;      // hit, distance, entry_x, entry_y, entry_z, zero fill
    logic wr_en = 1'b0;
    logic [sbsi_pkg::CFG_IDX_BITS-1:0] wr_idx = '0;
    logic [CB-1:0] wr_data = '0;

    segment_box_slab_intersect_core uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    longint box_lo [3];
    longint box_hi [3];
    seg_t pending_segs [$];
    clip_t expected_clips [$];
    int mismatches = 0;
    longint cycles = 0;
    int in_gap = 0;
    int out_gap = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint sx32(logic [CB-1:0] v);
        return longint'($signed(v));
    endfunction

    // fraction num/den, truncated, magnitude capped at 2.0
    function automatic longint slab_ratio(longint num, longint den);
        longint unsigned n, d, m, r;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        if (n >= 2*d)
            m = 2 << FB;
        else
        begin
            m = (n >= d) ? 1 : 0;
            r = m ? n - d : n;
            for (int i = 0; i < FB; i++)
            begin
                r = r << 1;
                m = m << 1;
                if (r >= d)
                begin
                    r = r - d;
                    m = m | 1;
                end
            end
        end
        return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic clip_t clip_segment(seg_t sg);
        clip_t res;
        longint s [3], d [3], off [3];
        longint lo, hi, a, b, t;
        longint unsigned am, p, root, cand;
        logic [127:0] sum, sq;
        bit hit;
        s[0] = sx32(sg.sx); s[1] = sx32(sg.sy); s[2] = sx32(sg.sz);
        d[0] = sx32(sg.ex) - s[0]; d[1] = sx32(sg.ey) - s[1]; d[2] = sx32(sg.ez) - s[2];
        lo = 0;
        hi = longint'(1) << FB;
        hit = 1;
        for (int i = 0; i < 3; i++)
            if (box_lo[i] > box_hi[i]) hit = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (!hit) break;
            if (d[i] == 0)
            begin
                if (s[i] < box_lo[i] || s[i] > box_hi[i]) hit = 0;
                continue;
            end
            a = slab_ratio(box_lo[i] - s[i], d[i]);
            b = slab_ratio(box_hi[i] - s[i], d[i]);
            if (b < a)
            begin
                t = a; a = b; b = t;
            end
            if (b < lo || a > hi)
            begin
                hit = 0;
                continue;
            end
            if (a > lo) lo = a;
            if (b < hi) hi = b;
        end
        res.hit = hit; res.distance = '0; res.px = '0; res.py = '0; res.pz = '0;
        if (!hit) return res;
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            am = d[i] < 0 ? -d[i] : d[i];
            p = (am >> FB) * lo + (((am & ((64'd1 << FB) - 1)) * lo) >> FB);
            off[i] = d[i] < 0 ? -longint'(p) : longint'(p);
            sum = sum + 128'(p) * 128'(p);
        end
        res.px = CB'(s[0] + off[0]);
        res.py = CB'(s[1] + off[1]);
        res.pz = CB'(s[2] + off[2]);
        root = 0;
        for (int i = CB-1; i >= 0; i--)
        begin
            cand = root | (64'd1 << i);
            sq = 128'(cand) * 128'(cand);
            if (sq <= sum) root = cand;
        end
        res.distance = CB'(root);
        return res;
    endfunction

    // driver
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (s_axis_tvalid)
                    expected_clips.push_back(clip_segment(seg_t'(s_axis_tdata)));
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_segs.size() > 0)
                begin
                    s_axis_tdata <= pending_segs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    in_gap <= gap_len();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        clip_t exp_c;
        logic hit_o;
        logic [CB-1:0] d_o, x_o, y_o, z_o;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                hit_o = m_axis_tdata[0];
                d_o = m_axis_tdata[1 +: CB];
                x_o = m_axis_tdata[1+CB +: CB];
                y_o = m_axis_tdata[1+2*CB +: CB];
                z_o = m_axis_tdata[1+3*CB +: CB];
                if (expected_clips.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected item: %h", m_axis_tdata);
                end
                else
                begin
                    exp_c = expected_clips.pop_front();
                    if (exp_c.hit !== hit_o || exp_c.distance !== d_o || exp_c.px !== x_o ||
                        exp_c.py !== y_o || exp_c.pz !== z_o)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch exp %b %h %h %h %h got %b %h %h %h %h",
                                exp_c.hit, exp_c.distance, exp_c.px, exp_c.py, exp_c.pz,
                                hit_o, d_o, x_o, y_o, z_o);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(sbsi_pkg::cfg_idx_t idx, longint val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_idx <= idx;
        wr_data <= CB'(val);
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx <= sbsi_pkg::REG_MIN_Z) box_lo[idx] = sx32(CB'(val));
        else box_hi[idx - sbsi_pkg::REG_MAX_X] = sx32(CB'(val));
    endtask

    task automatic set_box(longint x0, longint y0, longint z0,
                           longint x1, longint y1, longint z1);
        write_reg(sbsi_pkg::REG_MIN_X, x0);
        write_reg(sbsi_pkg::REG_MIN_Y, y0);
        write_reg(sbsi_pkg::REG_MIN_Z, z0);
        write_reg(sbsi_pkg::REG_MAX_X, x1);
        write_reg(sbsi_pkg::REG_MAX_Y, y1);
        write_reg(sbsi_pkg::REG_MAX_Z, z1);
    endtask

    task automatic drain();
        while (pending_segs.size() > 0 || s_axis_tvalid || expected_clips.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [CB-1:0] rand_coord(int mode);
        unique case (mode)
            0: return $urandom();
            1: return CB'(longint'($urandom_range(0, 40 << 16)) - (20 << 16));
            default: return CB'(longint'($urandom_range(0, 8)) * (1 << 16) - (4 << 16));
        endcase
    endfunction

    function automatic seg_t rand_seg();
        seg_t sg;
        int mode;
        mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 3) == 0 ? 2 : 1);
        sg.sx = rand_coord(mode); sg.sy = rand_coord(mode); sg.sz = rand_coord(mode);
        sg.ex = rand_coord(mode); sg.ey = rand_coord(mode); sg.ez = rand_coord(mode);
        if ($urandom_range(0, 5) == 0) sg.ex = sg.sx;
        if ($urandom_range(0, 5) == 0) sg.ey = sg.sy;
        if ($urandom_range(0, 7) == 0) sg.ez = sg.sz;
        return sg;
    endfunction

    function automatic seg_t mk(longint a, longint b, longint c,
                                longint d, longint e, longint f);
        seg_t sg;
        sg.sx = CB'(a); sg.sy = CB'(b); sg.sz = CB'(c);
        sg.ex = CB'(d); sg.ey = CB'(e); sg.ez = CB'(f);
        return sg;
    endfunction

    localparam longint ONE = 1 << 16;
    localparam longint MAXC = 64'sh7fffffff;
    localparam longint MINC = -64'sh80000000;

    initial
    begin
        box_lo = '{MAXC, MAXC, MAXC};
        box_hi = '{MINC, MINC, MINC};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // inverted box after reset
        pending_segs.push_back(mk(0, 0, 0, ONE, ONE, ONE));
        pending_segs.push_back(mk(MINC, MINC, MINC, MAXC, MAXC, MAXC));
        drain();
        set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        pending_segs.push_back(mk(-4*ONE, 0, 0, 4*ONE, 0, 0));
        pending_segs.push_back(mk(4*ONE, ONE/2, 0, -4*ONE, ONE/2, 0));
        pending_segs.push_back(mk(0, 0, 0, 0, 0, 0));
        pending_segs.push_back(mk(2*ONE, 0, 0, 2*ONE, 0, 0));
        pending_segs.push_back(mk(ONE, ONE, ONE, 3*ONE, 3*ONE, 3*ONE));
        pending_segs.push_back(mk(-3*ONE, 0, 0, -ONE, 0, 0));
        pending_segs.push_back(mk(-3*ONE, 0, 0, -2*ONE, 0, 0));
        pending_segs.push_back(mk(0, 2*ONE, 0, 0, 2*ONE, ONE));
        pending_segs.push_back(mk(-3*ONE, -3*ONE, -3*ONE, 3*ONE, 3*ONE, 3*ONE));
        pending_segs.push_back(mk(-3*ONE, 3*ONE, 0, 3*ONE, -3*ONE, 0));
        pending_segs.push_back(mk(MINC, MINC, MINC, MAXC, MAXC, MAXC));
        pending_segs.push_back(mk(MAXC, 0, 0, MINC, 0, 0));
        pending_segs.push_back(mk(MINC, MAXC, MINC, MAXC, MINC, MAXC));
        pending_segs.push_back(mk(-2*ONE, 3*ONE, 0, 2*ONE, -ONE, 0));
        drain();
        set_box(MINC, MINC, MINC, MAXC, MAXC, MAXC);
        pending_segs.push_back(mk(MINC, MINC, MINC, MAXC, MAXC, MAXC));
        pending_segs.push_back(mk(MAXC, MAXC, MAXC, MINC, MINC, MINC));
        pending_segs.push_back(mk(0, 0, 0, -1, -1, -1));
        drain();
        for (int ph = 0; ph < 7; ph++)
        begin
            unique case (ph)
                0: set_box(-4*ONE, -4*ONE, -4*ONE, 4*ONE, 4*ONE, 4*ONE);
                1: set_box(-10*ONE, 0, -ONE, 2*ONE, 5*ONE, ONE);
                2: set_box(0, 0, 0, 0, 0, 0);
                3: set_box(ONE, -2*ONE, 3*ONE, 8*ONE, 2*ONE, 9*ONE);
                4: set_box(MINC, MINC, MINC, MAXC, MAXC, MAXC);
                5: set_box(-ONE, -ONE, -ONE, ONE, -2*ONE, ONE);
                default: set_box(-15*ONE, -15*ONE, -15*ONE, 15*ONE, 15*ONE, 15*ONE);
            endcase
            for (int n = 0; n < 100; n++)
                pending_segs.push_back(rand_seg());
            drain();
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
